// ===== rtl/core/packet_buffer_drop_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// packet_buffer_drop_scheduler_top_macros
// Assertion macros for the packet buffer scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PACKET_BUFFER_DROP_SCHEDULER_TOP_MACROS_SVH
`define PACKET_BUFFER_DROP_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PBDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbds assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define PBDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbds assertion failed: next-cycle implication");

`endif

// ===== rtl/core/pbds_pkg.sv =====
// ----------------------------------------------------------------------------
// pbds_pkg
// Widths, types and constants of the packet buffer drop scheduler.
// ----------------------------------------------------------------------------
package pbds_pkg;

	// Ring depth and derived widths
	localparam int BUF_DEPTH = 64;
	localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

	// Field widths
	localparam int ARR_W = 32;
	localparam int PT_W  = 20;
	localparam int TS_W  = 48;
	localparam int CAP_W = 7;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CNT_W:0]   cntx_t;
	typedef logic [ARR_W-1:0] arr_t;
	typedef logic [PT_W-1:0]  pt_t;
	typedef logic [TS_W-1:0]  ts_t;
	typedef logic [TS_W:0]    tsx_t;
	typedef logic [CAP_W-1:0] cap_t;

	localparam cap_t CAP_RESET = 7'd64;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_CHECK = 2'b10
	} state_t;

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		logic dropped;
		ts_t  service_start;
	} result_t;

endpackage

// ===== rtl/core/pbds_ram.sv =====
// ----------------------------------------------------------------------------
// pbds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/pbds_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbds_ctrl
// Ring sequencer: retires finished entries from the head of the finish-time
// ring one per cycle, then drops or appends the current packet.
// ----------------------------------------------------------------------------
`include "packet_buffer_drop_scheduler_top_macros.svh"

module pbds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pbds_pkg::arr_t    pkt_arrival,
	input  pbds_pkg::pt_t     pkt_duration,
	input  pbds_pkg::cnt_t    cap,
	input  logic              res_ready,
	output pbds_pkg::result_t res
);

	pbds_pkg::state_t state_q;
	pbds_pkg::idx_t   head_q;
	pbds_pkg::cnt_t   count_q;
	pbds_pkg::ts_t    last_q;
	pbds_pkg::arr_t   arrival_q;
	pbds_pkg::pt_t    ptime_q;

	pbds_pkg::idx_t   head_inc;
	pbds_pkg::idx_t   raddr;
	pbds_pkg::idx_t   tail;
	pbds_pkg::cntx_t  tail_sum;
	pbds_pkg::ts_t    head_finish;
	pbds_pkg::ts_t    start;
	pbds_pkg::tsx_t   finish_sum;
	pbds_pkg::ts_t    finish;
	logic             in_fire;
	logic             pop;
	logic             decide;
	logic             full;
	logic             push;

	assign in_ready = (state_q == pbds_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Head pointer advance with wrap
	assign head_inc = (head_q == pbds_pkg::idx_t'(pbds_pkg::BUF_DEPTH - 1)) ?
		'0 : head_q + pbds_pkg::idx_t'(1);

	// Retire while the head entry has finished by the arrival
	assign pop = (state_q == pbds_pkg::ST_CHECK) && (count_q != '0) &&
		(head_finish <= pbds_pkg::ts_t'(arrival_q));
	assign decide = (state_q == pbds_pkg::ST_CHECK) && !pop && res_ready;
	assign full   = (count_q >= cap);
	assign push   = decide && !full;

	// Read the next head early when popping so its data lands next cycle
	assign raddr = pop ? head_inc : head_q;

	// Tail slot for the append
	assign tail_sum = pbds_pkg::cntx_t'(head_q) + pbds_pkg::cntx_t'(count_q);
	assign tail = (tail_sum >= pbds_pkg::cntx_t'(pbds_pkg::BUF_DEPTH)) ?
		pbds_pkg::idx_t'(tail_sum - pbds_pkg::cntx_t'(pbds_pkg::BUF_DEPTH)) :
		pbds_pkg::idx_t'(tail_sum);

	// Start time and saturating finish time
	assign start = (pbds_pkg::ts_t'(arrival_q) > last_q) ?
		pbds_pkg::ts_t'(arrival_q) : last_q;
	assign finish_sum = pbds_pkg::tsx_t'(start) + pbds_pkg::tsx_t'(ptime_q);
	assign finish = finish_sum[pbds_pkg::TS_W] ? '1 : finish_sum[pbds_pkg::TS_W-1:0];

	pbds_ram #(
		.WIDTH(pbds_pkg::TS_W),
		.DEPTH(pbds_pkg::BUF_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (tail),
		.wdata (finish),
		.raddr (raddr),
		.rdata (head_finish)
	);

	// Sequencer and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbds_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				pbds_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= pbds_pkg::ST_CHECK;
					end
				end
				pbds_pkg::ST_CHECK: begin
					if (pop) begin
						head_q  <= head_inc;
						count_q <= count_q - pbds_pkg::cnt_t'(1);
					end else if (decide) begin
						state_q <= pbds_pkg::ST_IDLE;
						if (!full) begin
							count_q <= count_q + pbds_pkg::cnt_t'(1);
							last_q  <= finish;
						end
					end
				end
				default: begin
					state_q <= pbds_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Packet capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			arrival_q <= pkt_arrival;
			ptime_q   <= pkt_duration;
		end
	end

	// Result to output register
	always_comb begin
		res.valid         = decide;
		res.dropped       = full;
		res.service_start = full ? '0 : start;
	end

	`PBDS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1,
		count_q <= pbds_pkg::cnt_t'(pbds_pkg::BUF_DEPTH))
	`PBDS_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`PBDS_ASSERT_NXT(a_push_counts, clk, arst_n, push,
		count_q == $past(count_q) + pbds_pkg::cnt_t'(1))
	`PBDS_ASSERT_IMP(a_drop_only_full, clk, arst_n, res.valid && res.dropped,
		count_q >= cap)

endmodule

// ===== rtl/core/packet_buffer_drop_scheduler_top.sv =====
// Result: an accepted packet moves the sequencer to its check state, which retires
// finished entries, then registers the decision once the output register is free.
// A new packet is taken only while idle; the ring memory's single registered read
// port sets the pop rate. Reset: arst_n clears ring head, count, last finish time
// and output valid; cap_q returns to 64. Ring contents are not cleared (no sweep).
// ----------------------------------------------------------------------------
// packet_buffer_drop_scheduler_top
// Bounded FIFO packet buffer feeding one processor: drops packets that find
// the buffer full, otherwise reports each packet's start of service.
// ----------------------------------------------------------------------------
module packet_buffer_drop_scheduler_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pbds_pkg::arr_t pkt_arrival,
	input  pbds_pkg::pt_t  pkt_duration,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           dropped,
	output pbds_pkg::ts_t  service_start,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  pbds_pkg::cap_t buffer_capacity
);

	pbds_pkg::cap_t    cap_q;
	pbds_pkg::cnt_t    cap_eff;
	pbds_pkg::result_t res;
	logic              res_ready;
	logic              out_valid_q;
	logic              dropped_q;
	pbds_pkg::ts_t     start_q;

	// Capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= pbds_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= buffer_capacity;
		end
	end

	// Clamp capacity to ring depth
	assign cap_eff = (int'(cap_q) > pbds_pkg::BUF_DEPTH) ?
		pbds_pkg::cnt_t'(pbds_pkg::BUF_DEPTH) : pbds_pkg::cnt_t'(cap_q);

	pbds_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pkt_arrival  (pkt_arrival),
		.pkt_duration (pkt_duration),
		.cap          (cap_eff),
		.res_ready    (res_ready),
		.res          (res)
	);

	// Output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			dropped_q <= res.dropped;
			start_q   <= res.service_start;
		end
	end

	assign out_valid     = out_valid_q;
	assign dropped       = dropped_q;
	assign service_start = start_q;

endmodule

// ===== tb/pbds_sched_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbds_sched_checker
// Watches the packet, result and capacity channels of the packet buffer
// scheduler, predicts the drop decision and start time of every packet,
// and compares each result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module pbds_sched_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  pbds_pkg::arr_t pkt_arrival,
	input  pbds_pkg::pt_t  pkt_duration,
	input  logic           out_valid,
	input  logic           out_ready,
	input  logic           dropped,
	input  pbds_pkg::ts_t  service_start,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  pbds_pkg::cap_t buffer_capacity,
	output int             mismatches,
	output int             outstanding,
	output int             n_started,
	output int             n_dropped
);

	typedef struct {
		logic          dropped;
		pbds_pkg::ts_t service_start;
	} outcome_t;

	localparam pbds_pkg::ts_t TS_MAX = '1;

	// Scheduler state as seen by the predictor
	pbds_pkg::ts_t  queued_finish[$];
	pbds_pkg::ts_t  last_finish_ts;
	pbds_pkg::cap_t cap_setting;
	outcome_t       expected_outcomes[$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	// Retire finished entries, then drop or queue the packet
	function automatic outcome_t schedule_packet(input pbds_pkg::arr_t arr,
		input pbds_pkg::pt_t pt);
		int             limit;
		pbds_pkg::ts_t  svc_start;
		pbds_pkg::tsx_t fin;
		outcome_t       o;
		limit = (cap_setting > pbds_pkg::BUF_DEPTH) ? pbds_pkg::BUF_DEPTH :
			int'(cap_setting);
		while (queued_finish.size() > 0 && queued_finish[0] <= pbds_pkg::ts_t'(arr))
			void'(queued_finish.pop_front());
		if (queued_finish.size() >= limit) begin
			o.dropped       = 1'b1;
			o.service_start = '0;
		end else begin
			svc_start = (pbds_pkg::ts_t'(arr) > last_finish_ts) ?
				pbds_pkg::ts_t'(arr) : last_finish_ts;
			fin = pbds_pkg::tsx_t'(svc_start) + pbds_pkg::tsx_t'(pt);
			if (fin > pbds_pkg::tsx_t'(TS_MAX))
				fin = pbds_pkg::tsx_t'(TS_MAX);
			queued_finish = {queued_finish, pbds_pkg::ts_t'(fin)};
			last_finish_ts = pbds_pkg::ts_t'(fin);
			o.dropped       = 1'b0;
			o.service_start = svc_start;
		end
		return o;
	endfunction

	// Sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			queued_finish.delete();
			expected_outcomes.delete();
			last_finish_ts = '0;
			cap_setting    = pbds_pkg::CAP_RESET;
			mismatches     = 0;
			outstanding    = 0;
			n_started      = 0;
			n_dropped      = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_setting = buffer_capacity;

			// results are checked before this edge's packet is predicted
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected (dropped=%0b start=%0d)",
						dropped, service_start));
				end else begin
					want = expected_outcomes.pop_front();
					if (dropped !== want.dropped)
						report_mismatch($sformatf("dropped: expected %0b, got %0b",
							want.dropped, dropped));
					if (service_start !== want.service_start)
						report_mismatch($sformatf("service_start: expected %0d, got %0d",
							want.service_start, service_start));
				end
			end

			if (in_valid && in_ready) begin
				want = schedule_packet(pkt_arrival, pkt_duration);
				expected_outcomes = {expected_outcomes, want};
				if (want.dropped)
					n_dropped++;
				else
					n_started++;
			end

			outstanding = expected_outcomes.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives packets and capacity writes into the packet buffer scheduler with
// random idle gaps on the packet channel and random stalls on the result side;
// a checker beside the block predicts and compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	pbds_pkg::arr_t pkt_arrival;
	pbds_pkg::pt_t  pkt_duration;
	logic           out_valid;
	logic           out_ready;
	logic           dropped;
	pbds_pkg::ts_t  service_start;
	logic           cfg_valid;
	logic           cfg_ready;
	pbds_pkg::cap_t buffer_capacity;

	int             mismatches;
	int             outstanding;
	int             n_started;
	int             n_dropped;
	int             n_settings;
	int             cycle_count;
	bit             calm;
	bit             hold_off_req;
	pbds_pkg::arr_t stim_clock;

	packet_buffer_drop_scheduler_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pkt_arrival     (pkt_arrival),
		.pkt_duration    (pkt_duration),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.dropped         (dropped),
		.service_start   (service_start),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.buffer_capacity (buffer_capacity)
	);

	pbds_sched_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pkt_arrival     (pkt_arrival),
		.pkt_duration    (pkt_duration),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.dropped         (dropped),
		.service_start   (service_start),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.buffer_capacity (buffer_capacity),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.n_started       (n_started),
		.n_dropped       (n_dropped)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none in calm phases
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offer one packet and hold it until accepted, then maybe idle
	task automatic run_packet(input pbds_pkg::arr_t arr, input pbds_pkg::pt_t pt);
		int gap;
		@(negedge clk);
		in_valid     <= 1'b1;
		pkt_arrival  <= arr;
		pkt_duration <= pt;
		do @(posedge clk); while (!in_ready);
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Capacity writes only once every result is back
	task automatic set_capacity(input pbds_pkg::cap_t cap);
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		cfg_valid       <= 1'b1;
		buffer_capacity <= cap;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Mostly nondecreasing arrivals that overload the buffer, with
	// occasional long jobs, idle jumps and arrivals that step back
	task automatic random_phase(input pbds_pkg::cap_t cap, input int n, input int spread);
		int             r;
		pbds_pkg::arr_t arr;
		pbds_pkg::pt_t  pt;
		set_capacity(cap);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				pt = pbds_pkg::pt_t'($urandom_range(0, 20'hFFFFF));
			else if (r < 10)
				pt = '0;
			else
				pt = pbds_pkg::pt_t'($urandom_range(1, spread));
			r = $urandom_range(0, 99);
			if (r < 5)
				stim_clock += pbds_pkg::arr_t'($urandom_range(1000, 2_000_000));
			else if (r < 95)
				stim_clock += pbds_pkg::arr_t'($urandom_range(0, spread * 3 / 4));
			arr = stim_clock;
			if (r >= 95 && stim_clock > 200)
				arr = stim_clock - pbds_pkg::arr_t'($urandom_range(1, 200));
			run_packet(arr, pt);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		bit hold_used;
		stall_left = 0;
		hold_used  = 1'b0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_used) begin
				hold_used  = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = idle_gap();
			end else begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results still expected",
			cycle_count, outstanding);
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int i;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		pkt_arrival     = '0;
		pkt_duration    = '0;
		cfg_valid       = 1'b0;
		buffer_capacity = pbds_pkg::CAP_RESET;
		calm            = 1'b0;
		hold_off_req    = 1'b0;
		n_settings      = 0;
		stim_clock      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single slot: zero-length job, queued job, full buffer, longest job
		set_capacity(7'd1);
		run_packet(32'd0, 20'd0);
		run_packet(32'd0, 20'd5);
		run_packet(32'd1, 20'd3);
		run_packet(32'd5, 20'hFFFFF);
		run_packet(32'd10, 20'd1);

		// zero capacity drops everything; latest arrival drains the ring
		set_capacity(7'd0);
		run_packet(32'd20, 20'd4);
		run_packet(32'hFFFF_FFFF, 20'hFFFFF);
		run_packet(32'd300, 20'd2);

		// burst at one arrival fills a small buffer
		set_capacity(7'd3);
		repeat (5) run_packet(32'd1_100_000, 20'd10);

		// capacity above ring depth, plus a step back in arrival
		set_capacity(7'd127);
		for (i = 0; i < 8; i++)
			run_packet(32'd1_200_000, pbds_pkg::pt_t'(i));
		run_packet(32'd1_200_000, 20'd0);
		run_packet(32'd1_199_950, 20'd3);

		stim_clock = 32'd2_000_000;
		hold_off_req = 1'b1;
		random_phase(pbds_pkg::CAP_RESET, 110, 60);
		random_phase(7'd2, 90, 40);
		calm = 1'b1;
		random_phase(7'd127, 110, 60);
		calm = 1'b0;
		random_phase(7'd1, 80, 30);
		random_phase(7'd5, 90, 50);
		random_phase(pbds_pkg::cap_t'($urandom_range(6, 63)), 90, 80);
		random_phase(pbds_pkg::cap_t'($urandom_range(65, 126)), 90, 200);
		random_phase(7'd64, 90, 20);

		// drain, then let any stray result show up
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d packets under %0d capacity settings: %0d started, %0d dropped",
			n_started + n_dropped, n_settings, n_started, n_dropped);
		$display("Capacities ranged from zero through above-depth, with a long result stall");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
